### rtl/lrf_pkg.sv
// Shared types and constants for the LCD rectangle fill byte generator.
// Used by lrf_front, lrf_queue, lrf_back and lcd_rect_fill_stream.
package lrf_pkg;

    localparam int MaxPanelSize = 1024;
    localparam int QueueDepth   = 4;

    localparam int CfgDataW = 11;
    localparam int CoordW   = 10;

    // Configuration register indexes
    localparam logic [0:0] RegPanelWidth  = 1'b0;
    localparam logic [0:0] RegPanelHeight = 1'b1;

    localparam logic [CfgDataW-1:0] ResetPanelWidth  = 11'd320;
    localparam logic [CfgDataW-1:0] ResetPanelHeight = 11'd240;

    // Panel command bytes
    localparam logic [7:0] CmdColumnWindow = 8'h2A;
    localparam logic [7:0] CmdRowWindow    = 8'h2B;
    localparam logic [7:0] CmdMemoryWrite  = 8'h2C;

    // Header byte positions
    localparam logic [3:0] HdrColCmd  = 4'd0;
    localparam logic [3:0] HdrXsHi    = 4'd1;
    localparam logic [3:0] HdrXsLo    = 4'd2;
    localparam logic [3:0] HdrXeHi    = 4'd3;
    localparam logic [3:0] HdrXeLo    = 4'd4;
    localparam logic [3:0] HdrRowCmd  = 4'd5;
    localparam logic [3:0] HdrYsHi    = 4'd6;
    localparam logic [3:0] HdrYsLo    = 4'd7;
    localparam logic [3:0] HdrYeHi    = 4'd8;
    localparam logic [3:0] HdrYeLo    = 4'd9;
    localparam logic [3:0] HdrMemCmd  = 4'd10;

    typedef enum logic [0:0] {
        FUNC_START = 1'b0,
        FUNC_TICK  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PIXELS
    } t_phase;

    // Classified word handed from front to back
    typedef struct packed {
        t_func              func;
        logic [CoordW-1:0]  xs;
        logic [CoordW-1:0]  xe;
        logic [CoordW-1:0]  ys;
        logic [CoordW-1:0]  ye;
        logic [15:0]        color;
        logic [CoordW-1:0]  rows;
    } t_cmd;

    typedef struct packed {
        logic       is_data;
        logic [7:0] data;
        logic       burst_end;
        logic       fill_end;
    } t_out;

endpackage

### rtl/lrf_front.sv
// Front end: panel size registers, input acceptance, clipping and drop of starts.
// Depends on lrf_pkg; pushes classified words into lrf_queue.
module lrf_front #(
    parameter int MAX_PANEL_SIZE = lrf_pkg::MaxPanelSize
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [0:0]                   i_cfg_addr,
    input  logic [lrf_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                         i_valid,
    input  logic [79:0]                  i_data,
    input  logic                         i_func,
    output logic                         o_ready,
    input  logic                         i_full,
    output logic                         o_push,
    output lrf_pkg::t_cmd                o_cmd
);
    import lrf_pkg::*;

    localparam logic [16:0] MaxP = 17'(MAX_PANEL_SIZE);

    logic [CfgDataW-1:0] r_panel_w, r_panel_h;
    logic [16:0] pw, ph, x, y, w, h, sx, sy, xe_full, ye_full, rows_full;
    logic        drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_w <= ResetPanelWidth;
            r_panel_h <= ResetPanelHeight;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                RegPanelWidth:  r_panel_w <= i_cfg_data;
                RegPanelHeight: r_panel_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        pw = ({6'd0, r_panel_w} > MaxP) ? MaxP : {6'd0, r_panel_w};
        ph = ({6'd0, r_panel_h} > MaxP) ? MaxP : {6'd0, r_panel_h};
        x  = {1'b0, i_data[15:0]};
        y  = {1'b0, i_data[31:16]};
        w  = {1'b0, i_data[47:32]};
        h  = {1'b0, i_data[63:48]};
        sx = x + w;
        sy = y + h;
        drop = (x >= pw) || (y >= ph) || (w == 17'd0) || (h == 17'd0);
        // clip the far edge to the panel, window ends are inclusive
        xe_full   = ((sx > pw) ? pw : sx) - 17'd1;
        ye_full   = ((sy > ph) ? ph : sy) - 17'd1;
        rows_full = ye_full - y;
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && o_ready && ((i_func == FUNC_TICK) || !drop);

    always_comb begin
        o_cmd.func  = t_func'(i_func);
        o_cmd.xs    = x[CoordW-1:0];
        o_cmd.xe    = xe_full[CoordW-1:0];
        o_cmd.ys    = y[CoordW-1:0];
        o_cmd.ye    = ye_full[CoordW-1:0];
        o_cmd.color = i_data[79:64];
        o_cmd.rows  = rows_full[CoordW-1:0];
    end

endmodule

### rtl/lrf_queue.sv
// Short queue of classified words between front and back end.
// Depends on lrf_pkg; depth must be a power of two.
module lrf_queue #(
    parameter int DEPTH = lrf_pkg::QueueDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lrf_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output lrf_pkg::t_cmd o_cmd
);
    import lrf_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + PtrW'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + PtrW'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CntW'(1);
                2'b01:   r_count <= r_count - CntW'(1);
                default: ;
            endcase
        end
    end

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CntW'(DEPTH) || i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue pop while empty");

endmodule

### rtl/lrf_back.sv
// Back end: fill sequencer that turns queued words into panel bytes.
// Depends on lrf_pkg; drives the registered output word.
module lrf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  lrf_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output lrf_pkg::t_out o_out
);
    import lrf_pkg::*;

    t_phase            r_phase, n_phase;
    logic [3:0]        r_hidx, n_hidx;
    logic [CoordW-1:0] r_xs, n_xs, r_xe, n_xe, r_ys, n_ys, r_ye, n_ye;
    logic [CoordW-1:0] r_rows, n_rows;
    logic [15:0]       r_color, n_color;
    logic [10:0]       r_rbc, n_rbc, r_last, n_last;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;
    logic              row_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_hidx      <= '0;
            r_rbc       <= '0;
            r_rows      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_hidx      <= n_hidx;
            r_rbc       <= n_rbc;
            r_rows      <= n_rows;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xs    <= n_xs;
        r_xe    <= n_xe;
        r_ys    <= n_ys;
        r_ye    <= n_ye;
        r_color <= n_color;
        r_last  <= n_last;
        r_out   <= n_out;
    end

    // take a word whenever the output register is free or drains this cycle
    assign o_pop    = i_q_valid && (!r_out_valid || i_ready);
    assign row_done = (r_rbc >= r_last);

    always_comb begin
        n_phase     = r_phase;
        n_hidx      = r_hidx;
        n_xs        = r_xs;
        n_xe        = r_xe;
        n_ys        = r_ys;
        n_ye        = r_ye;
        n_rows      = r_rows;
        n_color     = r_color;
        n_rbc       = r_rbc;
        n_last      = r_last;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        if (o_pop) begin
            case (i_cmd.func)
                FUNC_START: begin
                    // drop a start that lands during a fill
                    if (r_phase == PH_IDLE) begin
                        n_xs    = i_cmd.xs;
                        n_xe    = i_cmd.xe;
                        n_ys    = i_cmd.ys;
                        n_ye    = i_cmd.ye;
                        n_rows  = i_cmd.rows;
                        n_color = i_cmd.color;
                        n_last  = {i_cmd.xe - i_cmd.xs, 1'b1};
                        n_hidx  = '0;
                        n_rbc   = '0;
                        n_phase = PH_HEADER;
                    end
                end
                FUNC_TICK: begin
                    case (r_phase)
                        PH_HEADER: begin
                            n_out_valid = 1'b1;
                            n_hidx      = r_hidx + 4'd1;
                            n_out       = '{is_data: 1'b1, data: 8'd0,
                                            burst_end: 1'b0, fill_end: 1'b0};
                            case (r_hidx)
                                HdrColCmd: begin
                                    n_out.is_data   = 1'b0;
                                    n_out.data      = CmdColumnWindow;
                                    n_out.burst_end = 1'b1;
                                end
                                HdrXsHi: n_out.data = {6'd0, r_xs[9:8]};
                                HdrXsLo: n_out.data = r_xs[7:0];
                                HdrXeHi: n_out.data = {6'd0, r_xe[9:8]};
                                HdrXeLo: begin
                                    n_out.data      = r_xe[7:0];
                                    n_out.burst_end = 1'b1;
                                end
                                HdrRowCmd: begin
                                    n_out.is_data   = 1'b0;
                                    n_out.data      = CmdRowWindow;
                                    n_out.burst_end = 1'b1;
                                end
                                HdrYsHi: n_out.data = {6'd0, r_ys[9:8]};
                                HdrYsLo: n_out.data = r_ys[7:0];
                                HdrYeHi: n_out.data = {6'd0, r_ye[9:8]};
                                HdrYeLo: begin
                                    n_out.data      = r_ye[7:0];
                                    n_out.burst_end = 1'b1;
                                end
                                default: begin
                                    n_out.is_data   = 1'b0;
                                    n_out.data      = CmdMemoryWrite;
                                    n_out.burst_end = 1'b1;
                                    n_hidx          = '0;
                                    n_rbc           = '0;
                                    n_phase         = PH_PIXELS;
                                end
                            endcase
                        end
                        PH_PIXELS: begin
                            n_out_valid     = 1'b1;
                            n_out.is_data   = 1'b1;
                            n_out.data      = r_rbc[0] ? r_color[7:0] : r_color[15:8];
                            n_out.burst_end = row_done;
                            n_out.fill_end  = row_done && (r_rows == '0);
                            if (!row_done) begin
                                n_rbc = r_rbc + 11'd1;
                            end else if (r_rows == '0) begin
                                n_rbc   = '0;
                                n_phase = PH_IDLE;
                            end else begin
                                n_rbc  = '0;
                                n_rows = r_rows - CoordW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    a_fill_end_closes_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.fill_end) |-> (r_out.burst_end && r_out.is_data))
        else $error("fill end without burst end");
    a_header_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_hidx <= HdrMemCmd))
        else $error("header position out of range");
    a_idle_after_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && n_out.fill_end && o_pop) |=> (r_phase == PH_IDLE))
        else $error("sequencer not idle after last byte");

endmodule

### rtl/lcd_rect_fill_stream.sv
// Top level of the LCD rectangle fill byte generator.
// Depends on lrf_pkg, lrf_front, lrf_queue and lrf_back.
//
//  channel   direction  handshake                  payload
//  cfg       in         i_cfg_we                   i_cfg_addr (0 width, 1 height), i_cfg_data
//  s_axis    in         s_axis_tvalid/tready       tdata x,y,width,height,color; tuser func
//  m_axis    out        m_axis_tvalid/tready       tdata byte,burst_end; tuser is_data; tlast
//
// One input word per cycle sustained; a tick that yields a byte passes through
// the queue register and then the output register before it shows at m_axis.
// The input stalls only when the four-entry queue is full; the queue fills
// while m_axis_tready is held low. Synchronous active-low reset restores
// panel size 320 x 240 and an idle sequencer.
module lcd_rect_fill_stream #(
    parameter int MAX_PANEL_SIZE = lrf_pkg::MaxPanelSize,
    parameter int QUEUE_DEPTH    = lrf_pkg::QueueDepth
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [0:0]                   i_cfg_addr,
    input  logic [lrf_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [15:0] rect_x, [31:16] rect_y, [47:32] rect_width, [63:48] rect_height,
    // [79:64] fill_color
    input  logic [79:0]                  s_axis_tdata,
    // [0] func
    input  logic [0:0]                   s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [7:0] out_byte, [8] burst_end, [15:9] zero
    output logic [15:0]                  m_axis_tdata,
    // [0] is_data
    output logic [0:0]                   m_axis_tuser,
    // fill_end
    output logic                         m_axis_tlast
);
    import lrf_pkg::*;

    logic push, full, pop, q_valid;
    t_cmd push_cmd, q_cmd;
    t_out out_word;

    lrf_front #(.MAX_PANEL_SIZE(MAX_PANEL_SIZE)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .i_data     (s_axis_tdata),
        .i_func     (s_axis_tuser[0]),
        .o_ready    (s_axis_tready),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    lrf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    lrf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_out     (out_word)
    );

    assign m_axis_tdata = {7'd0, out_word.burst_end, out_word.data};
    assign m_axis_tuser = out_word.is_data;
    assign m_axis_tlast = out_word.fill_end;

endmodule
